### src/fdcs_pkg.sv
package fdcs_pkg;

   localparam int FFT_SIZE    = 64;
   localparam int LOG2_FFT    = $clog2(FFT_SIZE);
   localparam int HALF_FFT    = FFT_SIZE / 2;
   localparam int STREAMS_MAX = 4;
   localparam int STREAM_W    = 2;
   localparam int BIN_W       = 6;
   localparam int SAMPLE_W    = 16;
   localparam int USED_W      = 7;
   localparam int DELAY_W     = 7;
   localparam int PROD_K_W    = DELAY_W + BIN_W + 1;
   localparam int PHASE_W     = 9;
   localparam int PH_SHIFT    = PHASE_W - LOG2_FFT;
   localparam int QUARTER     = 128;
   localparam int QIDX_W      = 8;
   localparam int COEF_W      = 16;
   localparam int FRAC_BITS   = 15;
   localparam int ACC_W       = 2 * COEF_W + 2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_USED_BINS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY0    = 3'd1;

   localparam logic [USED_W-1:0] USED_BINS_RESET = 7'd56;

   localparam int SIN_TBL_BITS = (QUARTER + 1) * COEF_W;
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   typedef struct packed {
      logic                       active;
      logic [PHASE_W-1:0]         phase;
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
   } fdcs_job_type;

   // Quarter-wave sine of 2*pi*i/512 in Q1.15, evaluated once at elaboration.
   function automatic logic [SIN_TBL_BITS-1:0] build_sin_tbl();
      logic [63:0]              x;
      logic [63:0]              x2;
      logic [63:0]              term;
      logic signed [63:0]       sum;
      logic [SIN_TBL_BITS-1:0]  tbl;
      tbl = '0;
      for (int i = 0; i <= QUARTER; i++) begin
         x    = (PI_Q30 * 64'(i) + 64'd128) >> 8;
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n[0]) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         sum = (sum + 64'sd16384) >>> 15;
         if (sum > 64'sd32767) begin
            sum = 64'sd32767;
         end
         tbl[i*COEF_W +: COEF_W] = sum[COEF_W-1:0];
      end
      return tbl;
   endfunction

   localparam logic [SIN_TBL_BITS-1:0] SIN_TBL = build_sin_tbl();

endpackage

### src/fdcs_if.sv
interface fdcs_req_if;
   import fdcs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [STREAM_W-1:0]        stream;
   logic [BIN_W-1:0]           bin;
   logic signed [SAMPLE_W-1:0] sample_re;
   logic signed [SAMPLE_W-1:0] sample_im;

   modport source (output valid, stream, bin, sample_re, sample_im, input ready);
   modport sink (input valid, stream, bin, sample_re, sample_im, output ready);
endinterface

interface fdcs_rsp_if;
   import fdcs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_re;
   logic signed [SAMPLE_W-1:0] out_im;
   logic                       saturated;

   modport source (output valid, out_re, out_im, saturated, input ready);
   modport sink (input valid, out_re, out_im, saturated, output ready);
endinterface

### src/fdcs_front.sv
module fdcs_front #(
   parameter int STREAMS = fdcs_pkg::STREAMS_MAX
) (
   input  logic                                clock,
   input  logic                                reset,
   fdcs_req_if.sink                            req_chan,
   input  logic                                csr_write_en,
   input  logic [fdcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fdcs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                job_valid,
   input  logic                                job_ready,
   output fdcs_pkg::fdcs_job_type              job
);
   import fdcs_pkg::*;

   logic [USED_W-1:0]         used_bins_ff;
   logic signed [DELAY_W-1:0] delay_ff [STREAMS];

   logic [USED_W-1:0]          used_clip;
   logic [BIN_W+1:0]           win_lo;
   logic [BIN_W+1:0]           win_hi;
   logic [BIN_W+1:0]           bin_ext;
   logic                       stream_ok;
   logic                       in_window;
   logic signed [DELAY_W-1:0]  delay_sel;
   logic signed [BIN_W:0]      k_idx;
   logic signed [PROD_K_W-1:0] dk;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_bins_ff <= USED_BINS_RESET;
         for (int i = 0; i < STREAMS; i++) begin
            delay_ff[i] <= '0;
         end
      end else if (csr_write_en) begin
         if (csr_index == CSR_USED_BINS) begin
            used_bins_ff <= csr_wdata[USED_W-1:0];
         end
         for (int i = 0; i < STREAMS; i++) begin
            if (csr_index == CSR_IDX_W'(int'(CSR_DELAY0) + i)) begin
               delay_ff[i] <= csr_wdata[DELAY_W-1:0];
            end
         end
      end
   end

   always_comb begin
      used_clip = (used_bins_ff > USED_W'(FFT_SIZE)) ? USED_W'(FFT_SIZE) : used_bins_ff;
      win_lo    = (BIN_W+2)'(HALF_FFT) - (BIN_W+2)'(used_clip >> 1);
      win_hi    = (BIN_W+2)'(HALF_FFT) + (BIN_W+2)'(used_clip >> 1);
      bin_ext   = (BIN_W+2)'(req_chan.bin);
      stream_ok = 32'(req_chan.stream) < STREAMS;
      in_window = stream_ok && (bin_ext < (BIN_W+2)'(FFT_SIZE))
                  && (bin_ext >= win_lo) && (bin_ext < win_hi);
      delay_sel = '0;
      for (int i = 0; i < STREAMS; i++) begin
         if (req_chan.stream == STREAM_W'(i)) begin
            delay_sel = delay_ff[i];
         end
      end
      k_idx = $signed({1'b0, req_chan.bin}) - $signed((BIN_W+1)'(HALF_FFT));
      dk    = PROD_K_W'(delay_sel) * PROD_K_W'(k_idx);
   end

   assign req_chan.ready = job_ready;
   assign job_valid      = req_chan.valid;
   assign job.active     = in_window;
   assign job.phase      = PHASE_W'(dk[LOG2_FFT-1:0]) << PH_SHIFT;
   assign job.re         = req_chan.sample_re;
   assign job.im         = req_chan.sample_im;

endmodule

### src/fdcs_queue.sv
module fdcs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  fdcs_pkg::fdcs_job_type  push_job,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output fdcs_pkg::fdcs_job_type  pop_job
);
   import fdcs_pkg::*;

   fdcs_job_type entry_ff [2];
   logic         wr_ptr_ff;
   logic         wr_ptr_in;
   logic         rd_ptr_ff;
   logic         rd_ptr_in;
   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   logic         push;
   logic         pop;

   always_comb begin
      push_ready = (count_ff != 2'd2);
      pop_valid  = (count_ff != 2'd0);
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      wr_ptr_in  = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + 2'(push) - 2'(pop);
      pop_job    = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### src/fdcs_back.sv
module fdcs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_ready,
   input  fdcs_pkg::fdcs_job_type  job,
   fdcs_rsp_if.source              rsp_chan
);
   import fdcs_pkg::*;

   localparam logic signed [ACC_W-1:0] MAX_V = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] MIN_V = -MAX_V - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1 << (FRAC_BITS - 1));

   function automatic logic [SAMPLE_W:0] round_clip(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] v;
      logic                    sat;
      logic [SAMPLE_W-1:0]     res;
      v = (acc + HALF_LSB) >>> FRAC_BITS;
      sat = 1'b0;
      res = v[SAMPLE_W-1:0];
      if (v > MAX_V) begin
         sat = 1'b1;
         res = MAX_V[SAMPLE_W-1:0];
      end else if (v < MIN_V) begin
         sat = 1'b1;
         res = MIN_V[SAMPLE_W-1:0];
      end
      return {sat, res};
   endfunction

   logic                       s1_valid_ff;
   logic signed [COEF_W-1:0]   s1_cos_ff;
   logic signed [COEF_W-1:0]   s1_sin_ff;
   logic signed [SAMPLE_W-1:0] s1_re_ff;
   logic signed [SAMPLE_W-1:0] s1_im_ff;

   logic                                s2_valid_ff;
   logic signed [SAMPLE_W+COEF_W-1:0]   s2_rc_ff;
   logic signed [SAMPLE_W+COEF_W-1:0]   s2_is_ff;
   logic signed [SAMPLE_W+COEF_W-1:0]   s2_ic_ff;
   logic signed [SAMPLE_W+COEF_W-1:0]   s2_rs_ff;

   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_re_ff;
   logic signed [SAMPLE_W-1:0] out_im_ff;
   logic                       out_sat_ff;

   logic                       out_load;
   logic                       s2_load;
   logic                       s1_load;
   logic [1:0]                 quad;
   logic [QIDX_W-1:0]          idx_a;
   logic [QIDX_W-1:0]          idx_b;
   logic signed [COEF_W-1:0]   sin_a;
   logic signed [COEF_W-1:0]   sin_b;
   logic signed [COEF_W-1:0]   cos_in;
   logic signed [COEF_W-1:0]   sin_in;
   logic signed [ACC_W-1:0]    acc_re;
   logic signed [ACC_W-1:0]    acc_im;
   logic [SAMPLE_W:0]          res_re;
   logic [SAMPLE_W:0]          res_im;

   always_comb begin
      out_load  = !out_valid_ff || rsp_chan.ready;
      s2_load   = !s2_valid_ff || out_load;
      s1_load   = !s1_valid_ff || s2_load;
      job_ready = s1_load;

      quad  = job.phase[PHASE_W-1 -: 2];
      idx_a = QIDX_W'(job.phase[PHASE_W-3:0]);
      idx_b = QIDX_W'(QUARTER) - idx_a;
      sin_a = SIN_TBL[idx_a*COEF_W +: COEF_W];
      sin_b = SIN_TBL[idx_b*COEF_W +: COEF_W];
      case (quad)
         2'd0: begin
            sin_in = sin_a;
            cos_in = sin_b;
         end
         2'd1: begin
            sin_in = sin_b;
            cos_in = -sin_a;
         end
         2'd2: begin
            sin_in = -sin_a;
            cos_in = -sin_b;
         end
         default: begin
            sin_in = -sin_b;
            cos_in = sin_a;
         end
      endcase
      if (!job.active) begin
         sin_in = '0;
         cos_in = '0;
      end

      acc_re = ACC_W'(s2_rc_ff) + ACC_W'(s2_is_ff);
      acc_im = ACC_W'(s2_ic_ff) - ACC_W'(s2_rs_ff);
      res_re = round_clip(acc_re);
      res_im = round_clip(acc_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= job_valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_load) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && job_valid) begin
         s1_cos_ff <= cos_in;
         s1_sin_ff <= sin_in;
         s1_re_ff  <= job.re;
         s1_im_ff  <= job.im;
      end
      if (s2_load && s1_valid_ff) begin
         s2_rc_ff <= (SAMPLE_W+COEF_W)'(s1_re_ff) * (SAMPLE_W+COEF_W)'(s1_cos_ff);
         s2_is_ff <= (SAMPLE_W+COEF_W)'(s1_im_ff) * (SAMPLE_W+COEF_W)'(s1_sin_ff);
         s2_ic_ff <= (SAMPLE_W+COEF_W)'(s1_im_ff) * (SAMPLE_W+COEF_W)'(s1_cos_ff);
         s2_rs_ff <= (SAMPLE_W+COEF_W)'(s1_re_ff) * (SAMPLE_W+COEF_W)'(s1_sin_ff);
      end
      if (out_load && s2_valid_ff) begin
         out_re_ff  <= res_re[SAMPLE_W-1:0];
         out_im_ff  <= res_im[SAMPLE_W-1:0];
         out_sat_ff <= res_re[SAMPLE_W] | res_im[SAMPLE_W];
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_re    = out_re_ff;
   assign rsp_chan.out_im    = out_im_ff;
   assign rsp_chan.saturated = out_sat_ff;

endmodule

### src/freq_domain_cyclic_shift_top.sv
// Frequency-domain cyclic shift: every beat on req_chan carries a stream, an FFT bin and a
// complex Q1.15 sample, and yields exactly one beat on rsp_chan with the sample rotated by
// exp(-j*2*pi*d*k/64), rounded and saturated, or zero when the stream is out of range or the
// bin lies outside the centered window of used_bins bins (rounded down to even, at most 64).
// The block takes one beat per clock cycle while rsp_chan does not stall; a beat is written
// into the two-entry queue behind the classifier at the edge that accepts it, then passes
// the rotator's table lookup, multiplier and round-and-saturate registers to rsp_chan.
// The delay and window registers on the csr port must only be written while no beat is in
// flight.
module freq_domain_cyclic_shift_top #(
   parameter int STREAMS = fdcs_pkg::STREAMS_MAX
) (
   input  logic                            clock,
   input  logic                            reset,
   fdcs_req_if.sink                        req_chan,
   fdcs_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_en,
   input  logic [fdcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fdcs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fdcs_pkg::*;

   logic         front_valid;
   logic         front_ready;
   fdcs_job_type front_job;
   logic         back_valid;
   logic         back_ready;
   fdcs_job_type back_job;

   fdcs_front #(
      .STREAMS (STREAMS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .job_valid    (front_valid),
      .job_ready    (front_ready),
      .job          (front_job)
   );

   fdcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_job   (front_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_job    (back_job)
   );

   fdcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .job       (back_job),
      .rsp_chan  (rsp_chan)
   );

endmodule
